FILE: rtl/core/gts_pkg.sv
// Shared types and constants of the trilinear grid sampler.
`timescale 1ns / 1ps

package gts_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 32;
    localparam int INV_W     = 32;
    localparam int SIZE_W    = 6;
    localparam int IDX_W     = 5;
    localparam int FRAC_W    = 24;
    localparam int PROD_W    = 64;
    localparam int NODE_CW   = 34;
    localparam int BLEND_W   = 34;
    localparam int ACC_W     = 58;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z      = 2'd3;

    localparam logic [INV_W-1:0]  INV_SPACING_RST = 32'd65536;
    localparam logic [SIZE_W-1:0] SIZE_RST        = 6'd32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // sequencer steps of one in-grid query
    localparam logic [STEP_W-1:0] STEP_X_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_X_LAST  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_C_FIRST = 4'd3;
    localparam logic [STEP_W-1:0] STEP_C_LAST  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_Y0      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_Y1      = 4'd7;
    localparam logic [STEP_W-1:0] STEP_E0      = 4'd7;
    localparam logic [STEP_W-1:0] STEP_E1      = 4'd9;
    localparam logic [STEP_W-1:0] STEP_Z       = 4'd10;
    localparam logic [STEP_W-1:0] STEP_LAST    = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NODE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [INV_W-1:0]  inv_spacing;
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } t_pos;

    typedef struct packed {
        logic              ok;
        logic [FRAC_W-1:0] tx;
        logic [FRAC_W-1:0] ty;
        logic [FRAC_W-1:0] tz;
    } t_scale_res;

endpackage

FILE: rtl/core/gts_if.sv
// Handshake channels of the trilinear grid sampler: items, results, configuration.
`timescale 1ns / 1ps

interface gts_in_if import gts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [IDX_W-1:0]  node_i;
    logic [IDX_W-1:0]  node_j;
    logic [IDX_W-1:0]  node_k;
    logic [DATA_W-1:0] sample_in;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;

    modport source (
        output valid, operation, node_i, node_j, node_k, sample_in, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, operation, node_i, node_j, node_k, sample_in, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

interface gts_out_if import gts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] field_value;
    logic              outside;

    modport source (output valid, field_value, outside, input ready);
    modport sink (input valid, field_value, outside, output ready);
endinterface

interface gts_cfg_if import gts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/grid_trilinear_sampler.sv
// Top level of the trilinear grid sampler: sequencer, configuration and output register.
`timescale 1ns / 1ps

// Stores a GRID_DIM^3 grid of signed Q8.24 samples and answers point queries
// (signed Q16.16) with the trilinear blend of the eight neighbor samples, or
// zero with outside set when the point falls off the grid. A write item is
// stored when it is taken. A query inside the grid scales the point
// and finds the lower node, reads the eight neighbors as four pairs from the
// dual-port grid memory, and sends its seven dependent blends one after
// another through the single two-stage blend unit; the sampler takes no new
// item meanwhile. A query off the grid skips ST_RUN. A finished result waits
// in the output register while the next item is taken. The grid memory is
// not cleared; an entry must be written before a query reads it.
module grid_trilinear_sampler import gts_pkg::*; #(
    parameter int GRID_DIM = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gts_in_if.sink    i_in,
    gts_out_if.source o_out,
    gts_cfg_if.sink   i_cfg
);

    localparam int NW    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
    localparam int AW    = 3 * NW;
    localparam int DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam logic [AW-1:0] GD = AW'(GRID_DIM);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_cfg r_cfg;
    logic r_out_valid;
    logic signed [DATA_W-1:0] r_field;
    logic r_outside;
    logic signed [DATA_W-1:0] r_res;
    logic r_res_out;
    logic signed [DATA_W-1:0] r_c [4];
    logic signed [DATA_W-1:0] r_e [2];

    logic in_acc, q_load, wr_en, out_load;
    t_pos pos_in;
    t_scale_res scale_res;
    logic [NW-1:0] node [3];
    logic [1:0] q;
    logic [NW-1:0] ny_q, nz_q, nx_hi;
    logic [AW-1:0] waddr, addr_lo, addr_hi, a_addr;
    logic [DATA_W-1:0] rd_a, rd_b;
    logic signed [DATA_W-1:0] bl_lo, bl_hi;
    logic [FRAC_W-1:0] bl_t;
    logic signed [BLEND_W-1:0] bl_val;

    function automatic logic [AW-1:0] f_addr(input logic [AW-1:0] i, input logic [AW-1:0] j,
                                             input logic [AW-1:0] k);
        return (i * GD + j) * GD + k;
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [BLEND_W-1:0] v);
        logic signed [BLEND_W-1:0] hi_lim;
        logic signed [BLEND_W-1:0] lo_lim;
        hi_lim = BLEND_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo_lim = -hi_lim - BLEND_W'(1);
        if (v > hi_lim) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo_lim) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc = i_in.valid && i_in.ready;
    assign q_load = in_acc && (i_in.operation == OP_QUERY);
    // drop writes whose index lies beyond the grid
    assign wr_en  = in_acc && (i_in.operation == OP_WRITE) && (i_in.node_i < GRID_DIM)
                    && (i_in.node_j < GRID_DIM) && (i_in.node_k < GRID_DIM);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    assign pos_in.pos_x = i_in.pos_x;
    assign pos_in.pos_y = i_in.pos_y;
    assign pos_in.pos_z = i_in.pos_z;

    gts_scale #(
        .GRID_DIM (GRID_DIM),
        .NW       (NW)
    ) u_scale (
        .i_clk  (i_clk),
        .i_load (q_load),
        .i_pos  (pos_in),
        .i_cfg  (r_cfg),
        .o_res  (scale_res),
        .o_node (node)
    );

    // read pair q covers corners (x, y+q[0], z+q[1]) and (x+1, y+q[0], z+q[1])
    assign q      = r_step[1:0];
    assign ny_q   = node[1] + NW'(q[0]);
    assign nz_q   = node[2] + NW'(q[1]);
    assign nx_hi  = node[0] + NW'(1);
    assign addr_lo = f_addr(AW'(node[0]), AW'(ny_q), AW'(nz_q));
    assign addr_hi = f_addr(AW'(nx_hi), AW'(ny_q), AW'(nz_q));
    assign waddr   = f_addr(AW'(i_in.node_i), AW'(i_in.node_j), AW'(i_in.node_k));
    assign a_addr  = (r_state == ST_IDLE) ? waddr : addr_lo;

    gts_grid_mem #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_a_we    (wr_en),
        .i_a_addr  (a_addr),
        .i_a_wdata (i_in.sample_in),
        .o_a_rdata (rd_a),
        .i_b_addr  (addr_hi),
        .o_b_rdata (rd_b)
    );

    always_comb begin
        case (r_step)
            STEP_Y0: begin
                bl_lo = r_c[0];
                bl_hi = r_c[1];
                bl_t  = scale_res.ty;
            end
            STEP_Y1: begin
                bl_lo = r_c[2];
                bl_hi = r_c[3];
                bl_t  = scale_res.ty;
            end
            STEP_Z: begin
                bl_lo = r_e[0];
                bl_hi = r_e[1];
                bl_t  = scale_res.tz;
            end
            default: begin
                bl_lo = $signed(rd_a);
                bl_hi = $signed(rd_b);
                bl_t  = scale_res.tx;
            end
        endcase
    end

    gts_blend u_blend (
        .i_clk (i_clk),
        .i_lo  (bl_lo),
        .i_hi  (bl_hi),
        .i_t   (bl_t),
        .o_val (bl_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_spacing <= INV_SPACING_RST;
            r_cfg.size_x      <= SIZE_RST;
            r_cfg.size_y      <= SIZE_RST;
            r_cfg.size_z      <= SIZE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_INV_SPACING: r_cfg.inv_spacing <= i_cfg.data;
                REG_SIZE_X:      r_cfg.size_x      <= i_cfg.data[SIZE_W-1:0];
                REG_SIZE_Y:      r_cfg.size_y      <= i_cfg.data[SIZE_W-1:0];
                REG_SIZE_Z:      r_cfg.size_z      <= i_cfg.data[SIZE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (q_load) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_NODE;
            end
            ST_NODE: begin
                n_step = '0;
                if (scale_res.ok) begin
                    n_state = ST_RUN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RUN: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // capture blend results on their fixed steps
    always_ff @(posedge i_clk) begin
        if (r_state == ST_NODE && !scale_res.ok) begin
            r_res     <= '0;
            r_res_out <= 1'b1;
        end
        if (r_state == ST_RUN) begin
            if (r_step >= STEP_C_FIRST && r_step <= STEP_C_LAST) begin
                r_c[2'(r_step - STEP_C_FIRST)] <= bl_val[DATA_W-1:0];
            end
            if (r_step == STEP_E0) begin
                r_e[0] <= bl_val[DATA_W-1:0];
            end
            if (r_step == STEP_E1) begin
                r_e[1] <= bl_val[DATA_W-1:0];
            end
            if (r_step == STEP_LAST) begin
                r_res     <= f_sat(bl_val);
                r_res_out <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_field   <= r_res;
            r_outside <= r_res_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.field_value = r_field;
    assign o_out.outside     = r_outside;

`ifndef SYNTHESIS
    // grid writes only land while no query is in flight
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_state == ST_IDLE)
        else $error("grid write outside idle");

    // a query always starts with the scaling cycle
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_load |=> r_state == ST_MUL)
        else $error("query did not enter scaling");

    // step counter stays inside the schedule
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_step <= STEP_LAST)
        else $error("step counter past schedule");

    // hold a finished result while the output word is still unread
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_out.ready) |=> r_state == ST_DONE)
        else $error("result dropped while output full");

    // a new output word only follows a finished query
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("output word without finished query");
`endif

endmodule

FILE: rtl/core/gts_grid_mem.sv
// Dual-port grid sample memory with registered read data.
`timescale 1ns / 1ps

module gts_grid_mem import gts_pkg::*; #(
    parameter int AW    = 15,
    parameter int DEPTH = 32768
) (
    input  logic              i_clk,
    input  logic              i_a_we,
    input  logic [AW-1:0]     i_a_addr,
    input  logic [DATA_W-1:0] i_a_wdata,
    output logic [DATA_W-1:0] o_a_rdata,
    input  logic [AW-1:0]     i_b_addr,
    output logic [DATA_W-1:0] o_b_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_a_we) begin
            mem[i_a_addr] <= i_a_wdata;
        end
        o_a_rdata <= mem[i_a_addr];
    end

    always_ff @(posedge i_clk) begin
        o_b_rdata <= mem[i_b_addr];
    end

endmodule

FILE: rtl/core/gts_scale.sv
// Coordinate scaling, floor to lower node, grid range check and weights.
`timescale 1ns / 1ps

module gts_scale import gts_pkg::*; #(
    parameter int GRID_DIM = 32,
    parameter int NW       = 5
) (
    input  logic       i_clk,
    input  logic       i_load,
    input  t_pos       i_pos,
    input  t_cfg       i_cfg,
    output t_scale_res o_res,
    output logic [NW-1:0] o_node [3]
);

    localparam int EW = $clog2(GRID_DIM + 1);

    logic signed [PROD_W-1:0] r_p [3];
    logic [POS_W-1:0]   pos  [3];
    logic [SIZE_W-1:0]  size [3];
    logic [EW-1:0]      eff  [3];
    logic [NODE_CW-1:0] nd   [3];
    logic [NODE_CW-1:0] lim  [3];
    logic [2:0]         ok_v;

    assign pos[0]  = i_pos.pos_x;
    assign pos[1]  = i_pos.pos_y;
    assign pos[2]  = i_pos.pos_z;
    assign size[0] = i_cfg.size_x;
    assign size[1] = i_cfg.size_y;
    assign size[2] = i_cfg.size_z;

    // exact product, 32 fraction bits
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int a = 0; a < 3; a++) begin
                r_p[a] <= $signed(pos[a]) * $signed({1'b0, i_cfg.inv_spacing});
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            eff[a] = (int'(size[a]) > GRID_DIM) ? EW'(GRID_DIM) : EW'(size[a]);
            // floor plus half the size minus one
            nd[a]  = {{2{r_p[a][PROD_W-1]}}, r_p[a][PROD_W-1:PROD_W/2]}
                     + NODE_CW'(eff[a] >> 1) - NODE_CW'(1);
            lim[a] = NODE_CW'(eff[a]) - NODE_CW'(1);
            ok_v[a] = !nd[a][NODE_CW-1] && ($signed(nd[a]) < $signed(lim[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        o_res.ok <= &ok_v;
        o_res.tx <= r_p[0][PROD_W/2-1:PROD_W/2-FRAC_W];
        o_res.ty <= r_p[1][PROD_W/2-1:PROD_W/2-FRAC_W];
        o_res.tz <= r_p[2][PROD_W/2-1:PROD_W/2-FRAC_W];
        for (int a = 0; a < 3; a++) begin
            o_node[a] <= nd[a][NW-1:0];
        end
    end

endmodule

FILE: rtl/core/gts_blend.sv
// Two-stage linear blend lo*(1-t) + hi*t with round half up.
`timescale 1ns / 1ps

module gts_blend import gts_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [DATA_W-1:0]  i_lo,
    input  logic signed [DATA_W-1:0]  i_hi,
    input  logic [FRAC_W-1:0]         i_t,
    output logic signed [BLEND_W-1:0] o_val
);

    logic signed [DATA_W:0]   r_d;
    logic signed [DATA_W-1:0] r_lo;
    logic [FRAC_W-1:0]        r_t;
    logic signed [ACC_W-1:0]  r_s;

    // lo*(1-t) + hi*t rewritten as lo + (hi-lo)*t
    always_ff @(posedge i_clk) begin
        r_d  <= {i_hi[DATA_W-1], i_hi} - {i_lo[DATA_W-1], i_lo};
        r_lo <= i_lo;
        r_t  <= i_t;
    end

    always_ff @(posedge i_clk) begin
        r_s <= r_d * $signed({1'b0, r_t}) + (r_lo <<< FRAC_W)
               + (ACC_W'(1) <<< (FRAC_W - 1));
    end

    assign o_val = r_s[ACC_W-1:FRAC_W];

endmodule

FILE: tb/trilinear_checker.sv
// Scoreboard of the trilinear grid sampler: predicts each answer word and compares it.
`timescale 1ns / 1ps

module trilinear_checker import gts_pkg::*; #(
    parameter int GRID_DIM = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gts_in_if    i_items,
    gts_out_if   i_answers,
    gts_cfg_if   i_cfg,
    output int   o_pending,
    output int   o_mismatches,
    output int   o_checked,
    output int   o_off_grid
);

    typedef struct packed {
        logic [DATA_W-1:0] field_value;
        logic              outside;
    } t_answer;

    logic [DATA_W-1:0] grid_mem [GRID_DIM*GRID_DIM*GRID_DIM];
    logic [INV_W-1:0]  inv_spacing = INV_SPACING_RST;
    logic [SIZE_W-1:0] size_xyz [3] = '{SIZE_RST, SIZE_RST, SIZE_RST};
    t_answer           answers_due [$];
    int                mismatches = 0;
    int                checked = 0;
    int                off_grid = 0;

    // Scale one coordinate, find its lower node and the Q0.24 fraction.
    function automatic bit scale_axis(input logic [POS_W-1:0] pos, input logic [SIZE_W-1:0] size,
                                      output longint node, output longint frac);
        longint eff;
        longint prod;
        eff  = (size > GRID_DIM) ? longint'(GRID_DIM) : longint'(size);
        prod = longint'($signed(pos)) * longint'({32'd0, inv_spacing});
        node = (prod >>> 32) + eff / 2 - 1;
        frac = longint'(prod[31:32-FRAC_W]);
        return !(node < 0 || node >= eff - 1);
    endfunction

    // lo*(1-t) + hi*t, rounded half up
    function automatic longint blend_pair(longint lo, longint hi, longint t);
        longint acc;
        acc = lo * ((64'sd1 <<< FRAC_W) - t) + hi * t;
        return (acc + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic longint sample_at(longint i, longint j, longint k);
        return longint'($signed(grid_mem[int'((i * GRID_DIM + j) * GRID_DIM + k)]));
    endfunction

    function automatic t_answer answer_query(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                             logic [POS_W-1:0] pz);
        longint  nx, ny, nz, tx, ty, tz;
        longint  edge_x [4];
        longint  e0, e1, v;
        bit      hit;
        int      q;
        t_answer a;
        hit = scale_axis(px, size_xyz[0], nx, tx);
        hit = scale_axis(py, size_xyz[1], ny, ty) && hit;
        hit = scale_axis(pz, size_xyz[2], nz, tz) && hit;
        if (!hit) begin
            a.field_value = '0;
            a.outside     = 1'b1;
            return a;
        end
        // x first for the four (y,z) pairs, then y, then z
        for (q = 0; q < 4; q++) begin
            edge_x[q] = blend_pair(sample_at(nx, ny + (q & 1), nz + (q >> 1)),
                                   sample_at(nx + 1, ny + (q & 1), nz + (q >> 1)), tx);
        end
        e0 = blend_pair(edge_x[0], edge_x[1], ty);
        e1 = blend_pair(edge_x[2], edge_x[3], ty);
        v  = blend_pair(e0, e1, tz);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        a.field_value = v[DATA_W-1:0];
        a.outside     = 1'b0;
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            inv_spacing = INV_SPACING_RST;
            size_xyz    = '{SIZE_RST, SIZE_RST, SIZE_RST};
            answers_due.delete();
        end else begin
            if (i_answers.valid && i_answers.ready) begin
                if (answers_due.size() == 0) begin
                    $error("answer word with none outstanding: field_value %h outside %b",
                           i_answers.field_value, i_answers.outside);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    checked++;
                    if (want.outside) off_grid++;
                    if (i_answers.field_value !== want.field_value) begin
                        $error("field_value mismatch: expected %h, actual %h",
                               want.field_value, i_answers.field_value);
                        mismatches++;
                    end
                    if (i_answers.outside !== want.outside) begin
                        $error("outside mismatch: expected %b, actual %b",
                               want.outside, i_answers.outside);
                        mismatches++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_INV_SPACING: inv_spacing = i_cfg.data;
                    REG_SIZE_X:      size_xyz[0] = i_cfg.data[SIZE_W-1:0];
                    REG_SIZE_Y:      size_xyz[1] = i_cfg.data[SIZE_W-1:0];
                    REG_SIZE_Z:      size_xyz[2] = i_cfg.data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_items.valid && i_items.ready) begin
                if (i_items.operation == OP_WRITE) begin
                    if (i_items.node_i < GRID_DIM && i_items.node_j < GRID_DIM &&
                        i_items.node_k < GRID_DIM) begin
                        grid_mem[(int'(i_items.node_i) * GRID_DIM + int'(i_items.node_j))
                                 * GRID_DIM + int'(i_items.node_k)] = i_items.sample_in;
                    end
                end else begin
                    answers_due.push_back(answer_query(i_items.pos_x, i_items.pos_y,
                                                       i_items.pos_z));
                end
            end
        end
        o_pending    <= answers_due.size();
        o_mismatches <= mismatches;
        o_checked    <= checked;
        o_off_grid   <= off_grid;
    end

endmodule

FILE: tb/testbench.sv
// Stimulus, register setups and verdict for the trilinear grid sampler.
`timescale 1ns / 1ps

module testbench;
    import gts_pkg::*;

    localparam int GRID_DIM = 32;
    localparam int SETTLE   = 24;
    localparam int LIMIT    = 400000;
    localparam int N_SETUPS = 8;

    typedef struct {
        logic [INV_W-1:0]  inv;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
        int                budget;
        bit                quiet;
    } t_setup;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              calm = 1'b0;
    int                cycle_count = 0;
    int                words_sent = 0;
    int                writes_sent = 0;
    int                queries_sent = 0;
    int                phase_words = 0;
    int                pending;
    int                mismatches;
    int                checked;
    int                off_grid;
    logic [INV_W-1:0]  cur_inv = INV_SPACING_RST;
    logic [SIZE_W-1:0] cur_size [3] = '{SIZE_RST, SIZE_RST, SIZE_RST};
    bit                filled [GRID_DIM*GRID_DIM*GRID_DIM];
    t_setup            plan [N_SETUPS];

    gts_in_if  in_ch ();
    gts_out_if out_ch ();
    gts_cfg_if cfg_ch ();

    grid_trilinear_sampler #(.GRID_DIM(GRID_DIM)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    trilinear_checker #(.GRID_DIM(GRID_DIM)) scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_items      (in_ch),
        .i_answers    (out_ch),
        .i_cfg        (cfg_ch),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked),
        .o_off_grid   (off_grid)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 24);
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic longint eff_size(logic [SIZE_W-1:0] size);
        return (size > GRID_DIM) ? longint'(GRID_DIM) : longint'(size);
    endfunction

    // Lower node of one coordinate under the current setup; 1 when it is on the grid.
    function automatic bit lands_inside(logic [POS_W-1:0] pos, logic [SIZE_W-1:0] size,
                                        output longint node);
        longint eff;
        eff  = eff_size(size);
        node = ((longint'($signed(pos)) * longint'({32'd0, cur_inv})) >>> 32) + eff / 2 - 1;
        return node >= 0 && node < eff - 1;
    endfunction

    // Pick a coordinate aimed at a chosen cell, now and then just past either edge.
    function automatic logic [POS_W-1:0] aim_axis(logic [SIZE_W-1:0] size);
        longint      eff, slot, scaled, pos;
        logic [31:0] frac;
        eff = eff_size(size);
        if (eff < 2 || cur_inv == '0) return $urandom();
        case ($urandom_range(19))
            0: slot = -1;
            1: slot = eff - 1;
            default: slot = $urandom_range(int'(eff) - 2);
        endcase
        frac = $urandom();
        if ($urandom_range(9) == 0) frac = '0;
        else if ($urandom_range(9) == 0) frac = '1;
        scaled = ((slot - eff / 2 + 1) <<< 32) + longint'({32'd0, frac});
        pos    = scaled / longint'({32'd0, cur_inv});
        if (pos > 64'sd2147483647) pos = 64'sd2147483647;
        if (pos < -64'sd2147483648) pos = -64'sd2147483648;
        return pos[POS_W-1:0];
    endfunction

    task automatic send_word(logic op, logic [IDX_W-1:0] i, logic [IDX_W-1:0] j,
                             logic [IDX_W-1:0] k, logic [DATA_W-1:0] smp,
                             logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic [POS_W-1:0] pz);
        if (!calm) begin
            while ($urandom_range(99) < 24) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.node_i    <= i;
        in_ch.node_j    <= j;
        in_ch.node_k    <= k;
        in_ch.sample_in <= smp;
        in_ch.pos_x     <= px;
        in_ch.pos_y     <= py;
        in_ch.pos_z     <= pz;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
        phase_words++;
        if (op == OP_WRITE) writes_sent++;
        else queries_sent++;
    endtask

    task automatic store_entry(logic [IDX_W-1:0] i, logic [IDX_W-1:0] j, logic [IDX_W-1:0] k,
                               logic [DATA_W-1:0] smp);
        filled[{i, j, k}] = 1'b1;
        send_word(OP_WRITE, i, j, k, smp, $urandom(), $urandom(), $urandom());
    endtask

    task automatic probe(logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [POS_W-1:0] pz);
        longint           nx, ny, nz;
        logic [IDX_W-1:0] i, j, k;
        bit               hit;
        int               q;
        hit = lands_inside(px, cur_size[0], nx);
        hit = lands_inside(py, cur_size[1], ny) && hit;
        hit = lands_inside(pz, cur_size[2], nz) && hit;
        // load every neighbor the blend reads, refresh a few that already hold data
        if (hit) begin
            for (q = 0; q < 8; q++) begin
                i = IDX_W'(nx + (q & 1));
                j = IDX_W'(ny + ((q >> 1) & 1));
                k = IDX_W'(nz + (q >> 2));
                if (!filled[{i, j, k}] || $urandom_range(9) == 0) begin
                    store_entry(i, j, k, pick_sample());
                end
            end
        end
        send_word(OP_QUERY, IDX_W'($urandom()), IDX_W'($urandom()), IDX_W'($urandom()),
                  $urandom(), px, py, pz);
    endtask

    // Hold the sender until every answer is back and the last write has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic apply_setup(t_setup s);
        drain();
        set_reg(REG_INV_SPACING, s.inv);
        set_reg(REG_SIZE_X, DATA_W'(s.sx));
        set_reg(REG_SIZE_Y, DATA_W'(s.sy));
        set_reg(REG_SIZE_Z, DATA_W'(s.sz));
        cfg_ch.valid <= 1'b0;
        cur_inv  = s.inv;
        cur_size = '{s.sx, s.sy, s.sz};
    endtask

    initial begin
        int p;
        int r;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_WRITE;
        in_ch.node_i    = '0;
        in_ch.node_j    = '0;
        in_ch.node_k    = '0;
        in_ch.sample_in = '0;
        in_ch.pos_x     = '0;
        in_ch.pos_y     = '0;
        in_ch.pos_z     = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_INV_SPACING;
        cfg_ch.data     = '0;

        plan[0] = '{INV_SPACING_RST, SIZE_RST, SIZE_RST, SIZE_RST, 170, 1'b0};
        plan[1] = '{32'h0000_0001, 6'd2, 6'd2, 6'd2, 80, 1'b0};
        plan[2] = '{32'hFFFF_FFFF, 6'd63, 6'd33, 6'd32, 120, 1'b0};
        plan[3] = '{32'h0000_8000, 6'd0, 6'd1, 6'd5, 50, 1'b0};
        plan[4] = '{32'h0000_0000, 6'd7, 6'd3, 6'd4, 60, 1'b0};
        plan[5] = '{32'h0003_0000, 6'd12, 6'd32, 6'd9, 200, 1'b1};
        plan[6] = '{32'h0000_0400, 6'd32, 6'd17, 6'd2, 120, 1'b0};
        plan[7] = '{$urandom_range(32'h0008_0000, 32'h0000_4000),
                    SIZE_W'($urandom_range(32, 2)), SIZE_W'($urandom_range(32, 2)),
                    SIZE_W'($urandom_range(32, 2)), 130, 1'b0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner indices and extreme samples, the middle cell at both fraction ends,
        // the top cell, and points just past either edge or far off the grid
        store_entry(5'd0, 5'd0, 5'd0, 32'h8000_0000);
        store_entry(5'd31, 5'd31, 5'd31, 32'h7FFF_FFFF);
        store_entry(5'd31, 5'd0, 5'd17, 32'h0000_0000);
        probe(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        probe(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        probe(32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF);
        probe(32'h0010_0000, 32'h0000_0000, 32'h0000_0000);
        probe(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        probe(32'h0000_0000, 32'hFFF0_FFFF, 32'h0000_0000);

        for (p = 0; p < N_SETUPS; p++) begin
            if (p > 0) apply_setup(plan[p]);
            calm <= plan[p].quiet;
            phase_words = 0;
            while (phase_words < plan[p].budget) begin
                r = $urandom_range(99);
                if (r < 12) begin
                    store_entry(IDX_W'($urandom()), IDX_W'($urandom()), IDX_W'($urandom()),
                                pick_sample());
                end else if (r < 30) begin
                    probe($urandom(), $urandom(), $urandom());
                end else begin
                    probe(aim_axis(cur_size[0]), aim_axis(cur_size[1]), aim_axis(cur_size[2]));
                end
            end
        end
        drain();

        $display("Drove %0d words (%0d grid writes, %0d queries) over %0d register setups.",
                 words_sent, writes_sent, queries_sent, N_SETUPS);
        $display("Compared %0d answers, %0d off the grid; spacing and sizes hit both extremes.",
                 checked, off_grid);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
